/* rtl/acclk_pkg.sv */
package acclk_pkg;

  // Field widths
  localparam int YEAR_W      = 12;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int WEEKDAY_W   = 3;
  localparam int HOUR_W      = 5;
  localparam int MINUTE_W    = 6;
  localparam int SPEED_W     = 6;
  localparam int TPM_W       = 24;
  localparam int SET_YEAR_W  = 13;
  localparam int SET_MDAY_W  = 6;
  localparam int SET_HOUR_W  = 5;
  localparam int SET_MIN_W   = 6;

  // Period is (base_ticks + speed/2) / speed, at most 25 bits
  localparam int PERIOD_W    = TPM_W + 1;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = TPM_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_TICKS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_FACTOR = 2'd1;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  // Reset values
  localparam logic [TPM_W-1:0]     TPM_RESET     = 24'd60000;
  localparam logic [SPEED_W-1:0]   SPEED_RESET   = 6'd1;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 25'd60000;
  localparam logic [MINUTE_W-1:0]  MINUTE_RESET  = 6'd0;
  localparam logic [HOUR_W-1:0]    HOUR_RESET    = 5'd12;
  localparam logic [WEEKDAY_W-1:0] WEEKDAY_RESET = 3'd2;
  localparam logic [DAY_W-1:0]     DAY_RESET     = 5'd1;
  localparam logic [MONTH_W-1:0]   MONTH_RESET   = 4'd1;
  localparam logic [YEAR_W-1:0]    YEAR_RESET    = 12'd2020;

  // Calendar limits
  localparam logic [MINUTE_W-1:0]  MINUTE_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0]    HOUR_LAST    = 5'd23;
  localparam logic [WEEKDAY_W-1:0] WEEKDAY_LAST = 3'd6;
  localparam logic [MONTH_W-1:0]   MONTH_LAST   = 4'd12;

  // Reciprocal constants: x/100 = (x*5243) >> 19, x/7 = (x*9363) >> 16
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam logic [13:0] RECIP7   = 14'd9363;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [SET_YEAR_W-1:0] set_year;
    logic [MONTH_W-1:0]    set_month;
    logic [SET_MDAY_W-1:0] set_mday;
    logic [SET_HOUR_W-1:0] set_hour;
    logic [SET_MIN_W-1:0]  set_minute;
  } req_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day_of_month;
    logic [WEEKDAY_W-1:0] weekday;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SPEED_W-1:0]   speed;
    logic                 date_packet;
    logic                 time_packet;
    logic                 time_was_set;
  } rsp_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV_START,
    OP_TICK,
    OP_SET_YM,
    OP_LEAP_Q,
    OP_LEAP_FIN,
    OP_SET_DAY,
    OP_WD_MUL,
    OP_WD_SUM,
    OP_WD_FIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       period_dirty;
    logic       div_busy;
    logic [1:0] req_type;
    logic       advanced;
    logic       out_free;
  } dp_status_t;

  // Days in a month, given the leap flag of the year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Weekday offset of the month for the day-count sum
  function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] off;
    unique case (m)
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

/* rtl/accelerated_calendar_clock.sv */
// Accelerated calendar clock. Each base tick item advances a prescaler; when it
// reaches round(base_ticks / speed_factor) the model clock steps one
// minute with carries through the Gregorian calendar and a result item is sent.
// A set item loads the valid fields, clamps the day and recomputes the weekday;
// a report item returns the current time. Items are handled one at a time by a
// state machine: a tick runs S_TICK and S_TICK_CHK, an advancing one then the
// leap-year states S_LEAP_Q and S_LEAP_FIN; a set runs S_SET_YM, the leap-year
// states, S_SET_DAY and the weekday states S_WD_MUL, S_WD_SUM and S_WD_FIN. A
// result waits in S_EMIT until the output register is free. Any configuration
// write recomputes the period in a bit-serial divider, during which no item is
// taken. After reset the period is already valid and items are taken at once.
module accelerated_calendar_clock import acclk_pkg::*; #(
  parameter int TICK_COUNTER_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_item_t              req_item,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_item_t              rsp_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  acclk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  acclk_dpath #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_item  (req_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_item  (rsp_item)
  );

endmodule

/* rtl/acclk_div.sv */
module acclk_div import acclk_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PERIOD_W-1:0] dividend,
  input  logic [SPEED_W-1:0]  divisor,
  output logic                busy,
  output logic                done,
  output logic [PERIOD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PERIOD_W);

  logic [CNT_W-1:0]   cnt;
  logic [SPEED_W-1:0] rem;
  logic [SPEED_W-1:0] dvs;
  logic [SPEED_W:0]   trial;
  logic [SPEED_W:0]   diff;
  logic               fits;

  // Shift one dividend bit into the partial remainder and try the subtract
  assign trial = {rem, quotient[PERIOD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  // Control: count one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(PERIOD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[PERIOD_W-2:0], fits};
      rem      <= fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

/* rtl/acclk_dpath.sv */
module acclk_dpath import acclk_pkg::*; #(
  parameter int TICK_COUNTER_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  req_item_t              req_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   rsp_stall,
  output logic                   rsp_valid,
  output rsp_item_t              rsp_item
);

  localparam int CW    = TICK_COUNTER_WIDTH;
  localparam int CMP_W = (CW > PERIOD_W) ? CW : PERIOD_W;

  // Configuration and period
  logic [TPM_W-1:0]    tpm;
  logic [SPEED_W-1:0]  speed;
  logic [PERIOD_W-1:0] period;
  logic                dirty;

  // Counters and calendar
  logic [CW-1:0]        prescale;
  logic [CW-1:0]        since;
  logic [MINUTE_W-1:0]  minute_count;
  logic [HOUR_W-1:0]    hour_count;
  logic [WEEKDAY_W-1:0] weekday_count;
  logic [DAY_W-1:0]     day_count;
  logic [MONTH_W-1:0]   month_count;
  logic [YEAR_W-1:0]    year_count;
  logic                 leap;

  // Per-item flags
  logic flag_date, flag_time, flag_set, advanced;

  // Working registers
  req_item_t   req_r;
  logic [5:0]  lq;
  logic [5:0]  q100;
  logic [3:0]  q400;
  logic [12:0] wsum;

  // Divider
  logic                div_busy, div_done;
  logic [PERIOD_W-1:0] div_q;
  logic [PERIOD_W-1:0] div_dividend;
  logic [SPEED_W-1:0]  div_divisor;

  assign div_dividend = PERIOD_W'(tpm) + PERIOD_W'(speed >> 1);
  assign div_divisor  = (speed == '0) ? SPEED_W'(1) : speed;

  acclk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_START),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Tick arithmetic
  logic [CW-1:0] since_inc, pre_inc;
  logic          reach, announce;

  assign since_inc = (since == '1) ? since : since + 1'b1;
  assign pre_inc   = prescale + 1'b1;
  assign reach     = CMP_W'(pre_inc) >= CMP_W'(period);
  assign announce  = CMP_W'(since_inc) > CMP_W'(tpm >> 1);

  // Advance one minute with carries into the calendar
  logic [DAY_W-1:0]     mlen_cur;
  logic [MINUTE_W-1:0]  adv_minute;
  logic [HOUR_W-1:0]    adv_hour;
  logic [WEEKDAY_W-1:0] adv_weekday;
  logic [DAY_W-1:0]     adv_day;
  logic [MONTH_W-1:0]   adv_month;
  logic [YEAR_W-1:0]    adv_year;

  always_comb begin
    mlen_cur    = month_len(month_count, leap);
    adv_minute  = minute_count;
    adv_hour    = hour_count;
    adv_weekday = weekday_count;
    adv_day     = day_count;
    adv_month   = month_count;
    adv_year    = year_count;
    if (minute_count >= MINUTE_LAST) begin
      adv_minute = '0;
      if (hour_count >= HOUR_LAST) begin
        adv_hour    = '0;
        adv_weekday = (weekday_count >= WEEKDAY_LAST) ? '0 : weekday_count + 1'b1;
        if (day_count >= mlen_cur) begin
          adv_day = DAY_W'(1);
          if (month_count >= MONTH_LAST) begin
            adv_month = MONTH_W'(1);
            adv_year  = year_count + 1'b1;
          end else begin
            adv_month = month_count + 1'b1;
          end
        end else begin
          adv_day = day_count + 1'b1;
        end
      end else begin
        adv_hour = hour_count + 1'b1;
      end
    end else begin
      adv_minute = minute_count + 1'b1;
    end
  end

  // Set command: year and month candidates
  logic year_ok, month_ok, dch_ym;

  assign year_ok  = !req_r.set_year[SET_YEAR_W-1];
  assign month_ok = (req_r.set_month >= MONTH_W'(1)) && (req_r.set_month <= MONTH_LAST);
  assign dch_ym   = (year_ok && (req_r.set_year[YEAR_W-1:0] != year_count)) ||
                    (month_ok && (req_r.set_month != month_count));

  // Set command: day clamp, hour and minute
  logic [SET_MDAY_W-1:0] dv_raw, dv_clamp;
  logic                  hour_ok, min_ok, dch_day, tch;

  always_comb begin
    dv_raw = ((req_r.set_mday == '0) || (req_r.set_mday > 6'd31)) ?
             SET_MDAY_W'(day_count) : req_r.set_mday;
    dv_clamp = (dv_raw > SET_MDAY_W'(mlen_cur)) ? SET_MDAY_W'(mlen_cur) : dv_raw;
  end

  assign hour_ok = req_r.set_hour <= HOUR_LAST;
  assign min_ok  = req_r.set_minute <= MINUTE_LAST;
  assign dch_day = dv_clamp[DAY_W-1:0] != day_count;
  assign tch     = (hour_ok && (req_r.set_hour != hour_count)) ||
                   (min_ok && (req_r.set_minute != minute_count));

  // Leap year: y%4==0 and (y%100!=0 or (y/100)%4==0)
  logic [24:0] lq_prod;
  logic        div100, leap_n;

  assign lq_prod = 25'(year_count) * 25'(RECIP100);
  assign div100  = (13'(lq) * 13'd100) == 13'(year_count);
  assign leap_n  = (year_count[1:0] == 2'd0) && (!div100 || (lq[1:0] == 2'd0));

  // Weekday: shifted year, reciprocal quotients, then mod 7 of the registered sum
  logic [12:0] yy;
  logic [25:0] p100;
  logic [23:0] p400;
  logic [12:0] wsum_n;
  logic [26:0] p7;
  logic [9:0]  q7;
  logic [12:0] wrem;

  assign yy     = 13'(year_count) + 13'd400 - 13'(month_count < 4'd3);
  assign p100   = 26'(yy) * 26'(RECIP100);
  assign p400   = 24'(yy[12:2]) * 24'(RECIP100);
  assign wsum_n = yy + 13'(yy[12:2]) - 13'(q100) + 13'(q400) +
                  13'(month_offset(month_count)) + 13'(day_count) + 13'd6;
  assign p7     = 27'(wsum) * 27'(RECIP7);
  assign q7     = p7[25:16];
  assign wrem   = wsum - 13'(q7) * 13'd7;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm           <= TPM_RESET;
      speed         <= SPEED_RESET;
      period        <= PERIOD_RESET;
      dirty         <= 1'b0;
      prescale      <= '0;
      since         <= '0;
      minute_count  <= MINUTE_RESET;
      hour_count    <= HOUR_RESET;
      weekday_count <= WEEKDAY_RESET;
      day_count     <= DAY_RESET;
      month_count   <= MONTH_RESET;
      year_count    <= YEAR_RESET;
      leap          <= 1'b1;
      flag_date     <= 1'b0;
      flag_time     <= 1'b0;
      flag_set      <= 1'b0;
      advanced      <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      // Load the new period when the divider finishes
      if (div_done) begin
        period <= (div_q == '0) ? PERIOD_W'(1) : div_q;
      end

      unique case (cmd.op)
        OP_ACCEPT: begin
          flag_date <= 1'b0;
          flag_time <= 1'b0;
          flag_set  <= 1'b0;
          advanced  <= 1'b0;
        end
        OP_DIV_START: begin
          dirty <= 1'b0;
        end
        OP_TICK: begin
          since    <= since_inc;
          advanced <= 1'b0;
          if (speed != '0) begin
            if (reach) begin
              prescale      <= '0;
              advanced      <= 1'b1;
              minute_count  <= adv_minute;
              hour_count    <= adv_hour;
              weekday_count <= adv_weekday;
              day_count     <= adv_day;
              month_count   <= adv_month;
              year_count    <= adv_year;
              flag_date     <= (adv_hour == '0) && (adv_minute == '0);
              if (announce) begin
                flag_time <= 1'b1;
                since     <= '0;
              end
            end else begin
              prescale <= pre_inc;
            end
          end
        end
        OP_SET_YM: begin
          if (year_ok) year_count <= req_r.set_year[YEAR_W-1:0];
          if (month_ok) month_count <= req_r.set_month;
          flag_date <= dch_ym;
        end
        OP_LEAP_FIN: begin
          leap <= leap_n;
        end
        OP_SET_DAY: begin
          day_count <= dv_clamp[DAY_W-1:0];
          if (hour_ok) hour_count <= req_r.set_hour;
          if (min_ok) minute_count <= req_r.set_minute;
          flag_date <= flag_date | dch_day;
          flag_time <= tch;
          flag_set  <= tch;
          if (flag_date || dch_day || tch) prescale <= '0;
        end
        OP_WD_FIN: begin
          weekday_count <= wrem[WEEKDAY_W-1:0];
        end
        default: begin
        end
      endcase

      // Configuration writes; a period recompute follows any write
      if (cfg_we) begin
        dirty <= 1'b1;
        if (cfg_index == CFG_BASE_TICKS) begin
          tpm <= cfg_data;
        end else if (cfg_index == CFG_SPEED_FACTOR) begin
          if (cfg_data[SPEED_W-1:0] != speed) begin
            speed    <= cfg_data[SPEED_W-1:0];
            prescale <= '0;
          end
        end
      end

      // Output register: fill on emit, drain when taken
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) req_r <= req_item;
    if (cmd.op == OP_LEAP_Q) lq <= lq_prod[24:19];
    if (cmd.op == OP_WD_MUL) begin
      q100 <= p100[24:19];
      q400 <= p400[22:19];
    end
    if (cmd.op == OP_WD_SUM) begin
      wsum <= wsum_n;
    end
    if (cmd.op == OP_EMIT) begin
      rsp_item.year         <= year_count;
      rsp_item.month        <= month_count;
      rsp_item.day_of_month <= day_count;
      rsp_item.weekday      <= weekday_count;
      rsp_item.hour         <= hour_count;
      rsp_item.minute       <= minute_count;
      rsp_item.speed        <= speed;
      rsp_item.date_packet  <= flag_date;
      rsp_item.time_packet  <= flag_time;
      rsp_item.time_was_set <= flag_set;
    end
  end

  // Status to the controller
  assign status.period_dirty = dirty;
  assign status.div_busy     = div_busy;
  assign status.req_type     = req_r.req_type;
  assign status.advanced     = advanced;
  assign status.out_free     = !rsp_valid || !rsp_stall;

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (minute_count <= MINUTE_LAST) && (hour_count <= HOUR_LAST))
    else $error("minute or hour out of range");

  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    (period != '0) && (month_count != '0) && (month_count <= MONTH_LAST))
    else $error("zero period or month out of range");

endmodule

/* rtl/acclk_ctrl.sv */
module acclk_ctrl import acclk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_WAIT,
    S_DECODE,
    S_TICK,
    S_TICK_CHK,
    S_SET_YM,
    S_LEAP_Q,
    S_LEAP_FIN,
    S_SET_DAY,
    S_WD_MUL,
    S_WD_SUM,
    S_WD_FIN,
    S_EMIT
  } state_t;

  state_t state, state_next;

  // Take an item only when idle with a valid period
  assign req_stall = !((state == S_IDLE) && !status.period_dirty);

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (status.period_dirty) begin
          cmd.op     = OP_DIV_START;
          state_next = S_DIV_WAIT;
        end else if (req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) state_next = S_IDLE;
      end
      S_DECODE: begin
        unique case (status.req_type)
          REQ_TICK:   state_next = S_TICK;
          REQ_SET:    state_next = S_SET_YM;
          REQ_REPORT: state_next = S_EMIT;
          default:    state_next = S_IDLE;
        endcase
      end
      S_TICK: begin
        cmd.op     = OP_TICK;
        state_next = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        state_next = status.advanced ? S_LEAP_Q : S_IDLE;
      end
      S_SET_YM: begin
        cmd.op     = OP_SET_YM;
        state_next = S_LEAP_Q;
      end
      S_LEAP_Q: begin
        cmd.op     = OP_LEAP_Q;
        state_next = S_LEAP_FIN;
      end
      S_LEAP_FIN: begin
        cmd.op     = OP_LEAP_FIN;
        state_next = (status.req_type == REQ_SET) ? S_SET_DAY : S_EMIT;
      end
      S_SET_DAY: begin
        cmd.op     = OP_SET_DAY;
        state_next = S_WD_MUL;
      end
      S_WD_MUL: begin
        cmd.op     = OP_WD_MUL;
        state_next = S_WD_SUM;
      end
      S_WD_SUM: begin
        cmd.op     = OP_WD_SUM;
        state_next = S_WD_FIN;
      end
      S_WD_FIN: begin
        cmd.op     = OP_WD_FIN;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DECODE))
    else $error("accepted item not decoded");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> status.out_free)
    else $error("result emitted over a pending result");

endmodule

/* bench/accelerated_calendar_clock_tb.sv */
`timescale 1ns / 1ps

module accelerated_calendar_clock_tb;
  import acclk_pkg::*;

  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 40;

  // Codes the package leaves unnamed
  localparam logic [1:0]             REQ_UNUSED   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_item_t              req_item  = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_item_t              rsp_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  accelerated_calendar_clock dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Calendar state and registers as the testbench tracks them
  logic [TPM_W-1:0]     tpm_reg;
  logic [SPEED_W-1:0]   speed_reg;
  logic [MINUTE_W-1:0]  cur_minute;
  logic [HOUR_W-1:0]    cur_hour;
  logic [WEEKDAY_W-1:0] cur_wday;
  logic [DAY_W-1:0]     cur_mday;
  logic [MONTH_W-1:0]   cur_month;
  logic [YEAR_W-1:0]    cur_year;
  logic [31:0]          prescale;
  logic [31:0]          since_announce;

  req_item_t pending_reqs[$];
  rsp_item_t expected_times[$];
  int        error_count = 0;
  int        idle_pct    = IDLE_PCT;
  int        quiet_cycles;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic bit leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_in(input int y, input int m);
    int n;
    case (m)
      2:             n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  // Count days from a March-based year, 400 years ahead to stay positive
  function automatic int weekday_for(input int y, input int m, input int d);
    int jan_feb;
    int yy;
    int mm;
    int total;
    jan_feb = (m < 3) ? 1 : 0;
    yy = y + 400 - jan_feb;
    mm = m + 12 * jan_feb - 2;
    total = d + (31 * mm) / 12 + yy + yy / 4 - yy / 100 + yy / 400;
    // total mod 7 is 0 on Sunday; shift so that Monday is 0
    return (total + 6) % 7;
  endfunction

  task automatic reset_calendar();
    tpm_reg        = TPM_RESET;
    speed_reg      = SPEED_RESET;
    cur_minute     = MINUTE_RESET;
    cur_hour       = HOUR_RESET;
    cur_wday       = WEEKDAY_RESET;
    cur_mday       = DAY_RESET;
    cur_month      = MONTH_RESET;
    cur_year       = YEAR_RESET;
    prescale       = '0;
    since_announce = '0;
  endtask

  function automatic rsp_item_t calendar_now(input bit dp, input bit tp, input bit ws);
    rsp_item_t r;
    r.year         = cur_year;
    r.month        = cur_month;
    r.day_of_month = cur_mday;
    r.weekday      = cur_wday;
    r.hour         = cur_hour;
    r.minute       = cur_minute;
    r.speed        = speed_reg;
    r.date_packet  = dp;
    r.time_packet  = tp;
    r.time_was_set = ws;
    return r;
  endfunction

  // Carry one minute through hour, weekday, day, month and year
  task automatic step_minute();
    if (cur_minute < MINUTE_LAST) begin
      cur_minute = cur_minute + 1'b1;
    end else begin
      cur_minute = '0;
      if (cur_hour < HOUR_LAST) begin
        cur_hour = cur_hour + 1'b1;
      end else begin
        cur_hour = '0;
        cur_wday = (cur_wday >= WEEKDAY_LAST) ? '0 : cur_wday + 1'b1;
        if (cur_mday < days_in(cur_year, cur_month)) begin
          cur_mday = cur_mday + 1'b1;
        end else begin
          cur_mday = 5'd1;
          if (cur_month < MONTH_LAST) begin
            cur_month = cur_month + 1'b1;
          end else begin
            cur_month = 4'd1;
            cur_year  = cur_year + 1'b1;
          end
        end
      end
    end
  endtask

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_BASE_TICKS) begin
      tpm_reg = data;
    end else if (idx == CFG_SPEED_FACTOR) begin
      // only a real change of speed restarts the prescaler
      if (data[SPEED_W-1:0] != speed_reg) begin
        speed_reg = data[SPEED_W-1:0];
        prescale  = '0;
      end
    end
  endtask

  task automatic apply_request(input req_item_t r);
    longint period;
    int     y;
    int     m;
    int     d;
    int     h;
    int     mi;
    int     len;
    bit     dch;
    bit     tch;
    bit     tp;
    case (r.req_type)
      REQ_TICK: begin
        if (since_announce != 32'hFFFF_FFFF) since_announce = since_announce + 1;
        if (speed_reg != '0) begin
          period = (longint'(tpm_reg) + longint'(speed_reg) / 2) / longint'(speed_reg);
          if (period == 0) period = 1;
          prescale = prescale + 1;
          if (longint'(prescale) >= period) begin
            prescale = '0;
            step_minute();
            tp = (since_announce > (tpm_reg / 2));
            if (tp) since_announce = '0;
            expected_times.push_back(calendar_now(cur_hour == '0 && cur_minute == '0, tp, 1'b0));
          end
        end
      end
      REQ_SET: begin
        y   = int'(r.set_year);
        m   = int'(r.set_month);
        d   = int'(r.set_mday);
        h   = int'(r.set_hour);
        mi  = int'(r.set_minute);
        dch = 1'b0;
        tch = 1'b0;
        if (y <= 4095) begin
          if (y != cur_year) dch = 1'b1;
          cur_year = YEAR_W'(y);
        end
        if (m >= 1 && m <= MONTH_LAST) begin
          if (m != cur_month) dch = 1'b1;
          cur_month = MONTH_W'(m);
        end
        // fall back to the current day, then clamp to the month length
        len = days_in(cur_year, cur_month);
        if (d < 1 || d > 31) d = int'(cur_mday);
        if (d > len) d = len;
        if (d != cur_mday) dch = 1'b1;
        cur_mday = DAY_W'(d);
        if (h <= HOUR_LAST) begin
          if (h != cur_hour) tch = 1'b1;
          cur_hour = HOUR_W'(h);
        end
        if (mi <= MINUTE_LAST) begin
          if (mi != cur_minute) tch = 1'b1;
          cur_minute = MINUTE_W'(mi);
        end
        cur_wday = WEEKDAY_W'(weekday_for(cur_year, cur_month, cur_mday));
        if (dch || tch) prescale = '0;
        expected_times.push_back(calendar_now(dch, tch, tch));
      end
      REQ_REPORT: begin
        expected_times.push_back(calendar_now(1'b0, 1'b0, 1'b0));
      end
      default: ;
    endcase
  endtask

  task automatic compare_result(input rsp_item_t got, input rsp_item_t want);
    if (got.year !== want.year)
      log_mismatch($sformatf("year %0d, wanted %0d", got.year, want.year));
    if (got.month !== want.month)
      log_mismatch($sformatf("month %0d, wanted %0d", got.month, want.month));
    if (got.day_of_month !== want.day_of_month)
      log_mismatch($sformatf("day %0d, wanted %0d", got.day_of_month, want.day_of_month));
    if (got.weekday !== want.weekday)
      log_mismatch($sformatf("weekday %0d, wanted %0d", got.weekday, want.weekday));
    if (got.hour !== want.hour)
      log_mismatch($sformatf("hour %0d, wanted %0d", got.hour, want.hour));
    if (got.minute !== want.minute)
      log_mismatch($sformatf("minute %0d, wanted %0d", got.minute, want.minute));
    if (got.speed !== want.speed)
      log_mismatch($sformatf("speed %0d, wanted %0d", got.speed, want.speed));
    if (got.date_packet !== want.date_packet)
      log_mismatch($sformatf("date_packet %b, wanted %b", got.date_packet, want.date_packet));
    if (got.time_packet !== want.time_packet)
      log_mismatch($sformatf("time_packet %b, wanted %b", got.time_packet, want.time_packet));
    if (got.time_was_set !== want.time_was_set)
      log_mismatch($sformatf("time_was_set %b, wanted %b", got.time_was_set, want.time_was_set));
  endtask

  // Driver: track register writes, predict accepted items, present the next item
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (req_valid && !req_stall) apply_request(req_item);
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req_item  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_times.size() == 0) begin
          log_mismatch("result item with no prediction pending");
        end else begin
          compare_result(rsp_item, expected_times.pop_front());
        end
      end
      rsp_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: end the run once the handshakes go silent for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic req_item_t noisy_item(input logic [1:0] kind);
    req_item_t it;
    it.req_type   = kind;
    it.set_year   = SET_YEAR_W'($urandom_range(8191));
    it.set_month  = MONTH_W'($urandom_range(15));
    it.set_mday   = SET_MDAY_W'($urandom_range(63));
    it.set_hour   = SET_HOUR_W'($urandom_range(31));
    it.set_minute = SET_MIN_W'($urandom_range(63));
    return it;
  endfunction

  function automatic req_item_t set_item(input int y, input int m, input int d,
                                         input int h, input int mi);
    req_item_t it;
    it            = noisy_item(REQ_SET);
    it.set_year   = SET_YEAR_W'(y);
    it.set_month  = MONTH_W'(m);
    it.set_mday   = SET_MDAY_W'(d);
    it.set_hour   = SET_HOUR_W'(h);
    it.set_minute = SET_MIN_W'(mi);
    return it;
  endfunction

  // Well-formed set, leaning toward month ends, leap years and 23:59
  function automatic req_item_t calendar_set();
    int y;
    int m;
    int d;
    int h;
    int mi;
    case ($urandom_range(4))
      0:       y = 0;
      1:       y = 4095;
      2: begin
        case ($urandom_range(3))
          0:       y = 1900;
          1:       y = 2000;
          2:       y = 2100;
          default: y = 2024;
        endcase
      end
      default: y = $urandom_range(4095);
    endcase
    if ($urandom_range(2) == 0) m = $urandom_range(1) ? 2 : 12;
    else m = $urandom_range(1, 12);
    d  = $urandom_range(1) ? $urandom_range(28, 31) : $urandom_range(1, 31);
    h  = $urandom_range(1) ? 23 : $urandom_range(23);
    mi = $urandom_range(1) ? 59 : $urandom_range(59);
    return set_item(y, m, d, h, mi);
  endfunction

  function automatic req_item_t random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 58) return noisy_item(REQ_TICK);
    if (pick < 74) return calendar_set();
    if (pick < 82) return noisy_item(REQ_SET);
    if (pick < 94) return noisy_item(REQ_REPORT);
    return noisy_item(REQ_UNUSED);
  endfunction

  // Queue n items that the block acts on, plus any ignored ones drawn along the way
  task automatic fill_random(input int n);
    int        left;
    req_item_t it;
    left = n;
    while (left > 0) begin
      it = random_item();
      pending_reqs.push_back(it);
      if (it.req_type != REQ_UNUSED) left--;
    end
  endtask

  // Hold until every item is taken and every result is in, then let the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_times.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int tpm, input int speed);
    logic [CFG_DATA_W-1:0] word;
    drain();
    write_register(CFG_BASE_TICKS, CFG_DATA_W'(tpm));
    // junk above the speed field must be dropped
    word = CFG_DATA_W'($urandom);
    word[SPEED_W-1:0] = SPEED_W'(speed);
    write_register(CFG_SPEED_FACTOR, word);
  endtask

  task automatic run_phase(input int tpm, input int speed, input int n, input bit quiet);
    configure(tpm, speed);
    idle_pct = quiet ? 0 : IDLE_PCT;
    fill_random(n);
  endtask

  initial begin
    reset_calendar();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sets, reports and a tick that cannot fill the prescaler
    pending_reqs.push_back(noisy_item(REQ_REPORT));
    pending_reqs.push_back(noisy_item(REQ_TICK));
    pending_reqs.push_back(noisy_item(REQ_UNUSED));
    pending_reqs.push_back(set_item(8191, 0, 0, 31, 63));
    pending_reqs.push_back(set_item(2020, 1, 1, 12, 0));
    pending_reqs.push_back(set_item(4096, 0, 40, 5, 60));
    pending_reqs.push_back(set_item(2024, 2, 30, 0, 0));
    pending_reqs.push_back(set_item(2100, 15, 63, 31, 63));
    pending_reqs.push_back(set_item(0, 12, 31, 23, 59));
    pending_reqs.push_back(set_item(4095, 12, 31, 23, 59));
    pending_reqs.push_back(noisy_item(REQ_REPORT));

    // One tick per minute: year wrap, leap days, month and year ends
    configure(1, 1);
    pending_reqs.push_back(noisy_item(REQ_TICK));
    pending_reqs.push_back(set_item(2000, 2, 28, 23, 59));
    pending_reqs.push_back(noisy_item(REQ_TICK));
    pending_reqs.push_back(set_item(2100, 2, 28, 23, 59));
    pending_reqs.push_back(noisy_item(REQ_TICK));
    pending_reqs.push_back(set_item(2023, 4, 30, 23, 58));
    pending_reqs.push_back(noisy_item(REQ_TICK));
    pending_reqs.push_back(noisy_item(REQ_TICK));
    pending_reqs.push_back(set_item(1999, 12, 31, 23, 59));
    pending_reqs.push_back(noisy_item(REQ_TICK));

    // Extremes of both registers, then a stretch with no idling
    run_phase(1, 63, 110, 1'b0);
    run_phase(24'hFF_FFFF, 63, 30, 1'b0);
    run_phase(5, 0, 60, 1'b0);
    run_phase(12, 3, 150, 1'b1);

    // Unmapped register indexes must be ignored
    drain();
    write_register(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_register(CFG_SPARE_HI, CFG_DATA_W'($urandom));

    repeat (7) begin
      run_phase($urandom_range(1, 24),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 63), 100, 1'b0);
    end

    drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
